// File: hdl/spfa_pkg.sv
// ----------------------------------------------------------------------------
// spfa_pkg
// shared types, constants, magnitude and saturation helpers for the sph force accumulator
// ----------------------------------------------------------------------------
package spfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SUM_BITS  = 48;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ITER_BITS = $clog2(WORD_BITS);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] mag_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [SUM_BITS:0]    wide_t;
  typedef logic        [PROD_BITS-1:0] prod_t;

  localparam word_t MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam sum_t  SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam sum_t  SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  function automatic mag_t mag_of(input word_t v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic word_t sat_word(input wide_t v);
    word_t res;
    if (v > wide_t'(MAXV)) begin
      res = MAXV;
    end else if (v < wide_t'(MINV)) begin
      res = MINV;
    end else begin
      res = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic sum_t sat_sum(input wide_t v);
    sum_t res;
    if (v > wide_t'(SUM_MAX)) begin
      res = SUM_MAX;
    end else if (v < wide_t'(SUM_MIN)) begin
      res = SUM_MIN;
    end else begin
      res = v[SUM_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/spfa_mul.sv
// ----------------------------------------------------------------------------
// spfa_mul
// registered magnitude multiplier with q16.16 scaling and saturation
// ----------------------------------------------------------------------------
module spfa_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spfa_pkg::word_t a,
  input  spfa_pkg::word_t b,
  output logic           done,
  output spfa_pkg::prod_t prod,
  output spfa_pkg::word_t q
);
  import spfa_pkg::*;

  logic                              neg;
  logic [PROD_BITS-FRAC_BITS-1:0]    m;
  logic                              big;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_BITS'(mag_of(a)) * PROD_BITS'(mag_of(b));
      neg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    end
  end

  always_comb begin
    m   = prod[PROD_BITS-1:FRAC_BITS];
    big = |m[PROD_BITS-FRAC_BITS-1:WORD_BITS-1];
    if (neg) begin
      q = big ? MINV : -word_t'({1'b0, m[WORD_BITS-2:0]});
    end else begin
      q = big ? MAXV : word_t'({1'b0, m[WORD_BITS-2:0]});
    end
  end

endmodule

// File: hdl/spfa_div.sv
// ----------------------------------------------------------------------------
// spfa_div
// iterative restoring q16.16 divider, one quotient bit per cycle, saturating when the quotient cannot fit
// ----------------------------------------------------------------------------
module spfa_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spfa_pkg::word_t a,
  input  spfa_pkg::word_t b,
  output logic           done,
  output spfa_pkg::word_t q
);
  import spfa_pkg::*;

  localparam int NUM_BITS = WORD_BITS + FRAC_BITS;

  logic                 busy;
  logic [ITER_BITS-1:0] count;
  mag_t                 rem;
  mag_t                 shreg;
  mag_t                 quo;
  mag_t                 den;
  logic                 neg;
  mag_t                 ua;
  mag_t                 ub;
  logic [WORD_BITS:0]   trial;
  logic                 ge;
  mag_t                 quo_next;
  mag_t                 rem_next;

  always_comb begin
    ua       = mag_of(a);
    ub       = mag_of(b);
    trial    = {rem, shreg[WORD_BITS-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? WORD_BITS'(trial - {1'b0, den}) : trial[WORD_BITS-1:0];
    quo_next = {quo[WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // zero numerator, or quotient that cannot fit, finishes at once
        if (ua == '0 || NUM_BITS'(ua) >= (NUM_BITS'(ub) << (WORD_BITS - 1 - FRAC_BITS))) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= '0;
        end
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == ITER_BITS'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      den   <= ub;
      rem   <= WORD_BITS'(ua[WORD_BITS-1:FRAC_BITS]);
      shreg <= {ua[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo   <= '0;
      if (ua == '0) begin
        q <= '0;
      end else if (a[WORD_BITS-1] ^ b[WORD_BITS-1]) begin
        q <= MINV;
      end else begin
        q <= MAXV;
      end
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= shreg << 1;
      quo   <= quo_next;
      if (count == ITER_BITS'(WORD_BITS - 1)) begin
        q <= neg ? -word_t'(quo_next) : word_t'(quo_next);
      end
    end
  end

endmodule

// File: hdl/spfa_sqrt.sv
// ----------------------------------------------------------------------------
// spfa_sqrt
// iterative integer square root, one result bit per cycle, saturated output
// ----------------------------------------------------------------------------
module spfa_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spfa_pkg::prod_t rad,
  output logic           done,
  output spfa_pkg::word_t root
);
  import spfa_pkg::*;

  localparam int REM_BITS = WORD_BITS + 3;

  logic                 busy;
  logic [ITER_BITS-1:0] count;
  logic [REM_BITS-1:0]  rem;
  prod_t                rsh;
  mag_t                 res;
  logic [REM_BITS-1:0]  cur;
  logic [REM_BITS-1:0]  trial;
  logic                 ge;
  mag_t                 res_next;

  always_comb begin
    cur      = {rem[REM_BITS-3:0], rsh[PROD_BITS-1:PROD_BITS-2]};
    trial    = {1'b0, res, 2'b01};
    ge       = cur >= trial;
    res_next = {res[WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == ITER_BITS'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      res <= '0;
      rsh <= rad;
    end else if (busy) begin
      rem <= ge ? cur - trial : cur;
      res <= res_next;
      rsh <= rsh << 2;
      if (count == ITER_BITS'(WORD_BITS - 1)) begin
        root <= res_next[WORD_BITS-1] ? MAXV : word_t'(res_next);
      end
    end
  end

endmodule

// File: hdl/sph_pair_force_accumulate_unit.sv
// ----------------------------------------------------------------------------
// sph_pair_force_accumulate_unit
// accumulates sph pressure and viscosity force over a particle's neighbors
// a non-self neighbor is dominated by five divisions and one square root,
//   plus thirteen multiplies
// a self or coincident neighbor not marked last is accepted with no unit work
// the last neighbor adds two multiplies and then loads the result
// synchronous reset restores register defaults and clears sums and flag
// ----------------------------------------------------------------------------
module sph_pair_force_accumulate_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  spfa_pkg::word_t offset_x,
  input  spfa_pkg::word_t offset_y,
  input  spfa_pkg::word_t rel_vel_x,
  input  spfa_pkg::word_t rel_vel_y,
  input  spfa_pkg::word_t own_pressure,
  input  spfa_pkg::word_t other_pressure,
  input  logic [30:0]     other_density,
  input  logic [30:0]     own_density,
  input  logic            is_self,
  input  logic            last_neighbour,
  output logic            out_valid,
  input  logic            out_ready,
  output spfa_pkg::word_t force_x,
  output spfa_pkg::word_t force_y,
  output logic            coincident_seen
);
  import spfa_pkg::*;

  typedef enum logic [2:0] {
    CFG_MASS      = 3'd0,
    CFG_RADIUS    = 3'd1,
    CFG_SPIKY     = 3'd2,
    CFG_LAP_COEF  = 3'd3,
    CFG_VISCOSITY = 3'd4,
    CFG_GRAV_X    = 3'd5,
    CFG_GRAV_Y    = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    P_SQ_X, P_SQ_Y, P_SQRT, P_D, P_UX, P_UY, P_S, P_M1, P_Q1, P_C1, P_DD, P_C2,
    P_V1, P_V2, P_V3, P_WX, P_WY, P_AX, P_BX, P_TX, P_AY, P_BY, P_TY, P_GX, P_GY
  } step_t;

  // configuration
  logic [30:0] mass;
  logic [30:0] radius;
  word_t       spiky;
  word_t       lap_coef;
  logic [30:0] viscosity;
  word_t       grav_x;
  word_t       grav_y;

  // captured transaction
  word_t       ox, oy, vx, vy, pown, poth;
  logic [30:0] rho, rown;
  logic        last_r;

  // working values
  prod_t rad;
  word_t r, d, ux, uy, t, c, dd, v, wx, wy, acc_a, acc_b, fx_r, fy_r;
  sum_t  sum_x, sum_y;
  logic  coinc;

  state_t state;
  step_t  pc;

  // shared units
  logic  mul_start, div_start, sqrt_start;
  word_t mul_a, mul_b, div_a, div_b;
  logic  mul_done, div_done, sqrt_done, unit_done;
  prod_t mul_prod;
  word_t mul_q, div_q, sqrt_q;
  word_t mass_w, rho_w, rho2_w, rown_w, h_w;

  spfa_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod), .q(mul_q)
  );

  spfa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q)
  );

  spfa_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad(rad),
    .done(sqrt_done), .root(sqrt_q)
  );

  assign in_ready  = (state == ST_IDLE);
  assign unit_done = mul_done | div_done | sqrt_done;

  always_comb begin
    mass_w = word_t'({1'b0, mass});
    rho_w  = word_t'({1'b0, rho});
    rown_w = word_t'({1'b0, rown});
    h_w    = word_t'({1'b0, radius});
    // twice the density saturates once the top bit is set
    rho2_w = rho[30] ? MAXV : word_t'({1'b0, rho[29:0], 1'b0});
  end

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = ox;
    mul_b      = ox;
    div_a      = ox;
    div_b      = r;
    if (state == ST_ISSUE) begin
      unique case (pc)
        P_SQ_X: begin mul_start = 1'b1; mul_a = ox;       mul_b = ox;        end
        P_SQ_Y: begin mul_start = 1'b1; mul_a = oy;       mul_b = oy;        end
        P_SQRT: begin sqrt_start = 1'b1; end
        P_UX:   begin div_start = 1'b1; div_a = ox;       div_b = r;         end
        P_UY:   begin div_start = 1'b1; div_a = oy;       div_b = r;         end
        P_M1:   begin mul_start = 1'b1; mul_a = mass_w;   mul_b = t;         end
        P_Q1:   begin div_start = 1'b1; div_a = t;        div_b = rho2_w;    end
        P_C1:   begin mul_start = 1'b1; mul_a = t;        mul_b = spiky;     end
        P_DD:   begin mul_start = 1'b1; mul_a = d;        mul_b = d;         end
        P_C2:   begin mul_start = 1'b1; mul_a = c;        mul_b = dd;        end
        P_V1:   begin mul_start = 1'b1; mul_a = lap_coef; mul_b = d;         end
        P_V2:   begin mul_start = 1'b1; mul_a = v;        mul_b = mass_w;    end
        P_V3:   begin
          mul_start = 1'b1;
          mul_a     = v;
          mul_b     = word_t'({1'b0, viscosity});
        end
        P_WX:   begin div_start = 1'b1; div_a = vx;       div_b = rho_w;     end
        P_WY:   begin div_start = 1'b1; div_a = vy;       div_b = rho_w;     end
        P_AX:   begin mul_start = 1'b1; mul_a = ux;       mul_b = c;         end
        P_BX:   begin mul_start = 1'b1; mul_a = wx;       mul_b = v;         end
        P_AY:   begin mul_start = 1'b1; mul_a = uy;       mul_b = c;         end
        P_BY:   begin mul_start = 1'b1; mul_a = wy;       mul_b = v;         end
        P_GX:   begin mul_start = 1'b1; mul_a = grav_x;   mul_b = rown_w;    end
        P_GY:   begin mul_start = 1'b1; mul_a = grav_y;   mul_b = rown_w;    end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mass      <= 31'd65536;
      radius    <= 31'd1048576;
      spiky     <= '0;
      lap_coef  <= '0;
      viscosity <= '0;
      grav_x    <= '0;
      grav_y    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MASS:      mass      <= cfg_data[30:0];
        CFG_RADIUS:    radius    <= cfg_data[30:0];
        CFG_SPIKY:     spiky     <= word_t'(cfg_data);
        CFG_LAP_COEF:  lap_coef  <= word_t'(cfg_data);
        CFG_VISCOSITY: viscosity <= cfg_data[30:0];
        CFG_GRAV_X:    grav_x    <= word_t'(cfg_data);
        CFG_GRAV_Y:    grav_y    <= word_t'(cfg_data);
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= P_SQ_X;
      out_valid <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      coinc     <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ox     <= offset_x;
            oy     <= offset_y;
            vx     <= rel_vel_x;
            vy     <= rel_vel_y;
            pown   <= own_pressure;
            poth   <= other_pressure;
            rho    <= other_density;
            rown   <= own_density;
            last_r <= last_neighbour;
            if (!is_self && offset_x == '0 && offset_y == '0) begin
              coinc <= 1'b1;
            end
            if (!is_self && (offset_x != '0 || offset_y != '0)) begin
              pc    <= P_SQ_X;
              state <= ST_ISSUE;
            end else if (last_neighbour) begin
              pc    <= P_GX;
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          case (pc)
            P_D: begin
              d  <= sat_word(wide_t'(h_w) - wide_t'(r));
              pc <= P_UX;
            end
            P_S: begin
              t  <= sat_word(wide_t'(pown) + wide_t'(poth));
              pc <= P_M1;
            end
            P_TX: begin
              sum_x <= sat_sum(wide_t'(sum_x) +
                               wide_t'(sat_word(wide_t'(acc_a) + wide_t'(acc_b))));
              pc    <= P_AY;
            end
            P_TY: begin
              sum_y <= sat_sum(wide_t'(sum_y) +
                               wide_t'(sat_word(wide_t'(acc_a) + wide_t'(acc_b))));
              if (last_r) begin
                pc <= P_GX;
              end else begin
                state <= ST_IDLE;
              end
            end
            default: state <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (unit_done) begin
            case (pc)
              P_SQ_X: rad   <= mul_prod;
              P_SQ_Y: rad   <= rad + mul_prod;
              P_SQRT: r     <= sqrt_q;
              P_UX:   ux    <= div_q;
              P_UY:   uy    <= div_q;
              P_M1:   t     <= mul_q;
              P_Q1:   t     <= div_q;
              P_C1:   c     <= mul_q;
              P_DD:   dd    <= mul_q;
              P_C2:   c     <= (mul_q == MINV) ? MAXV : -mul_q;
              P_V1:   v     <= mul_q;
              P_V2:   v     <= mul_q;
              P_V3:   v     <= mul_q;
              P_WX:   wx    <= div_q;
              P_WY:   wy    <= div_q;
              P_AX:   acc_a <= mul_q;
              P_BX:   acc_b <= mul_q;
              P_AY:   acc_a <= mul_q;
              P_BY:   acc_b <= mul_q;
              P_GX:   fx_r  <= sat_word(wide_t'(sum_x) + wide_t'(mul_q));
              P_GY:   fy_r  <= sat_word(wide_t'(sum_y) + wide_t'(mul_q));
              default: begin end
            endcase
            if (pc == P_GY) begin
              state <= ST_OUT;
            end else begin
              pc    <= step_t'(pc + 5'd1);
              state <= ST_ISSUE;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            force_x         <= fx_r;
            force_y         <= fy_r;
            coincident_seen <= coinc;
            sum_x           <= '0;
            sum_y           <= '0;
            coinc           <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a shared unit only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done || sqrt_done) |-> state == ST_WAIT)
    else $error("shared unit finished outside the wait state");

  // loading a result clears the accumulators and the flag
  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || out_ready)) |=>
      (out_valid && sum_x == '0 && sum_y == '0 && !coinc))
    else $error("result load did not clear the accumulators");

  // a new result only appears from the output step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside the output step");

endmodule
